// ===== hdl/oltbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list table package
// Shared widths, command and status codes, and the control word that the
// controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package oltbl_pkg;

  // Field widths of the request and response channels.
  localparam int CMD_W    = 3;
  localparam int POS_W    = 10;
  localparam int ITEM_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 10;

  // Parameter defaults and the largest supported table.
  localparam int CAPACITY_DEF    = 512;
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int CAPACITY_MAX    = 4096;

  // Wide enough for any index or count of the largest table.
  localparam int IDX_MAX_W = $clog2(CAPACITY_MAX + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_SORTED = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // Control word seen by every cell. The index is the insert or delete
  // position during an update and the probe address during a read.
  typedef struct packed {
    cell_op_t               op;
    logic                   by_addr;
    logic [IDX_MAX_W-1:0]   index;
    logic [IDX_MAX_W-1:0]   count;
  } cell_ctrl_t;

  // Number of register stages in the result tree: one every three levels.
  function automatic int tree_lat(int capacity);
    return $clog2(capacity) / 3;
  endfunction

endpackage

// ===== hdl/oltbl_if.sv =====
// ----------------------------------------------------------------------------
// Ordered list table channels
// Valid/ready channels for the command requests and the responses.
// ----------------------------------------------------------------------------
interface oltbl_req_if;
  import oltbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  position;
  logic [ITEM_W-1:0] item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface oltbl_rsp_if;
  import oltbl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ITEM_W-1:0]   read_value;
  logic [POS_W-1:0]    found_position;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, read_value, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, entry_count,
                  output ready);
endinterface

// ===== hdl/oltbl_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list table cell
// Holds one table entry, shifts with its neighbors on insert and delete, and
// flags itself for the result tree on an address or key match.
// ----------------------------------------------------------------------------
module oltbl_cell #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = oltbl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  oltbl_pkg::cell_ctrl_t  ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   hit
);
  import oltbl_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (MY_IDX == ctrl.index) begin
          value <= new_value;
        end else if (MY_IDX > ctrl.index) begin
          value <= left_value;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= ctrl.index) begin
          value <= right_value;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

  // Only entries below the count take part in a key search.
  always_comb begin
    if (ctrl.by_addr) begin
      hit = (MY_IDX == ctrl.index);
    end else begin
      hit = (value == key) && (MY_IDX < ctrl.count);
    end
  end

endmodule

// ===== hdl/oltbl_tree.sv =====
// ----------------------------------------------------------------------------
// Ordered list table result tree
// Priority tree over all cells that returns the lowest flagged cell, with a
// register stage after every third level.
// ----------------------------------------------------------------------------
module oltbl_tree #(
  parameter int CAPACITY    = oltbl_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = oltbl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          leaf_hit   [CAPACITY],
  input  logic [VALUE_WIDTH-1:0]        leaf_value [CAPACITY],
  output logic                          root_hit,
  output logic [$clog2(CAPACITY)-1:0]   root_index,
  output logic [VALUE_WIDTH-1:0]        root_value
);
  import oltbl_pkg::*;

  localparam int LEVELS = $clog2(CAPACITY);
  localparam int IW     = LEVELS;
  localparam int N      = 1 << LEVELS;

  typedef struct packed {
    logic                   hit;
    logic [IW-1:0]          idx;
    logic [VALUE_WIDTH-1:0] value;
  } node_t;

  // Heap order: node n has children 2n and 2n+1, leaves sit at N..2N-1.
  node_t nodes [1:2*N-1];

  for (genvar g = 0; g < N; g++) begin : g_leaf
    if (g < CAPACITY) begin : g_used
      assign nodes[N+g] = '{hit: leaf_hit[g], idx: IW'(g), value: leaf_value[g]};
    end else begin : g_pad
      assign nodes[N+g] = '0;
    end
  end

  for (genvar n = 1; n < N; n++) begin : g_node
    localparam int DEPTH     = $clog2(n + 1) - 1;
    localparam bit REG_STAGE = ((LEVELS - DEPTH) % 3) == 0;
    node_t merged;

    assign merged = nodes[2*n].hit ? nodes[2*n] : nodes[2*n+1];

    if (REG_STAGE) begin : g_reg
      node_t held;
      always_ff @(posedge clk) begin
        held <= merged;
      end
      assign nodes[n] = held;
    end else begin : g_comb
      assign nodes[n] = merged;
    end
  end

  assign root_hit   = nodes[1].hit;
  assign root_index = nodes[1].idx;
  assign root_value = nodes[1].value;

endmodule

// ===== hdl/ordered_list_table_engine.sv =====
// ----------------------------------------------------------------------------
// Ordered list table engine
// Positional table of up to CAPACITY values kept in a row of shifting cells,
// with insert, delete, get, find and sorted find commands.
// ----------------------------------------------------------------------------
// The table is a row of CAPACITY cells, each holding one entry. Insert and
// delete move every later entry one place in the update state, so an
// insert or a delete passes through acceptance, update and response load
// before the next request can be accepted, and a rejected request goes
// from acceptance straight to the response load. Reads go through a
// priority tree over all cells that has a register stage every third level,
// TREE_LAT = floor(ceil(log2(CAPACITY)) / 3) stages (3 at the default size).
// A get or a find waits until the tree output is valid. A sorted find is a
// binary search in which every probe is one pass through that tree, and a
// search makes at most floor(log2(count)) + 1 probes. The response sits in
// an output register, so a new request is accepted while an earlier
// response still waits for its taker. Entries are not cleared at reset;
// only entries below the count are read. Out-of-range positions, a full
// table and unused command codes give an error status and leave the table
// unchanged.
// ----------------------------------------------------------------------------
module ordered_list_table_engine #(
  parameter int CAPACITY    = oltbl_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = oltbl_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  oltbl_req_if.sink    req,
  oltbl_rsp_if.source  rsp
);
  import oltbl_pkg::*;

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IW       = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int TREE_LAT = tree_lat(CAPACITY);
  localparam int WW       = (TREE_LAT > 0) ? $clog2(TREE_LAT + 1) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_PROBE  = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  // Control state.
  state_t                state;
  logic [CNT_W-1:0]      count;
  logic                  out_valid;

  // Working registers of the request in flight.
  cmd_t                  cmd;
  cell_op_t              op;
  logic                  by_addr;
  logic [IDX_MAX_W-1:0]  index;
  logic [VALUE_WIDTH-1:0] key;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hi;
  logic [WW-1:0]         wait_cnt;
  status_t               res_status;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [CNT_W-1:0]      res_fpos;

  // Output register.
  status_t               out_status;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [CNT_W-1:0]      out_fpos;
  logic [CNT_W-1:0]      out_count;

  // Cell row and result tree.
  cell_ctrl_t            ctrl;
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic                  cell_hit   [CAPACITY];
  logic                  root_hit;
  logic [IW-1:0]         root_index;
  logic [VALUE_WIDTH-1:0] root_value;

  // Request decode.
  logic                  req_accept;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  table_full;
  logic [CNT_W:0]        mid_sum;
  logic                  resp_load;

  assign req.ready  = (state == ST_IDLE);
  assign req_accept = req.valid && req.ready;
  assign pos_ext    = CMP_W'(req.position);
  assign cnt_ext    = CMP_W'(count);
  assign table_full = (count == CNT_W'(CAPACITY));
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign resp_load  = (state == ST_RESP) && (!out_valid || rsp.ready);

  // The cells only shift during the update cycle.
  always_comb begin
    ctrl.op      = (state == ST_UPDATE) ? op : CELL_HOLD;
    ctrl.by_addr = by_addr;
    ctrl.index   = index;
    ctrl.count   = IDX_MAX_W'(count);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_value;
    logic [VALUE_WIDTH-1:0] right_value;

    if (g == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_left
      assign left_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_right
      assign right_value = cell_value[g+1];
    end

    oltbl_cell #(
      .IDX         (g),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (key),
      .key         (key),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[g]),
      .hit         (cell_hit[g])
    );
  end

  oltbl_tree #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_tree (
    .clk        (clk),
    .leaf_hit   (cell_hit),
    .leaf_value (cell_value),
    .root_hit   (root_hit),
    .root_index (root_index),
    .root_value (root_value)
  );

  // Sequencer. A request is decoded at acceptance; errors go straight to the
  // response, updates shift in the update state, reads wait for the tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      op      <= CELL_HOLD;
      by_addr <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_accept) begin
            cmd        <= cmd_t'(req.command);
            key        <= req.item_value[VALUE_WIDTH-1:0];
            index      <= IDX_MAX_W'(req.position);
            res_value  <= '0;
            res_fpos   <= '0;
            wait_cnt   <= '0;
            case (req.command)
              CMD_INSERT: begin
                if (table_full) begin
                  res_status <= STAT_FULL;
                  state      <= ST_RESP;
                end else if (pos_ext > cnt_ext) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_RESP;
                end else begin
                  res_status <= STAT_OK;
                  op         <= CELL_INSERT;
                  state      <= ST_UPDATE;
                end
              end
              CMD_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_RESP;
                end else begin
                  res_status <= STAT_OK;
                  op         <= CELL_DELETE;
                  state      <= ST_UPDATE;
                end
              end
              CMD_GET: begin
                if (pos_ext >= cnt_ext) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_RESP;
                end else begin
                  res_status <= STAT_OK;
                  by_addr    <= 1'b1;
                  state      <= ST_WAIT;
                end
              end
              CMD_FIND: begin
                res_status <= STAT_OK;
                by_addr    <= 1'b0;
                state      <= ST_WAIT;
              end
              CMD_SORTED: begin
                res_status <= STAT_OK;
                by_addr    <= 1'b1;
                lo         <= '0;
                hi         <= count;
                state      <= ST_PROBE;
              end
              default: begin
                res_status <= STAT_RANGE;
                state      <= ST_RESP;
              end
            endcase
          end
        end

        ST_UPDATE: begin
          if (op == CELL_INSERT) begin
            count <= count + 1'b1;
          end else begin
            count <= count - 1'b1;
          end
          op    <= CELL_HOLD;
          state <= ST_RESP;
        end

        // Opens the next binary search probe, or closes a search that missed
        // with the insertion point.
        ST_PROBE: begin
          if (lo < hi) begin
            index    <= IDX_MAX_W'(mid_sum[CNT_W:1]);
            wait_cnt <= '0;
            state    <= ST_WAIT;
          end else begin
            res_status <= STAT_MISS;
            res_value  <= '0;
            res_fpos   <= lo;
            state      <= ST_RESP;
          end
        end

        // The tree output is valid once its register stages have refilled.
        ST_WAIT: begin
          if (wait_cnt == WW'(TREE_LAT)) begin
            case (cmd)
              CMD_GET: begin
                res_value <= root_value;
                state     <= ST_RESP;
              end
              CMD_FIND: begin
                if (root_hit) begin
                  res_value <= root_value;
                  res_fpos  <= CNT_W'(root_index);
                end else begin
                  res_status <= STAT_MISS;
                end
                state <= ST_RESP;
              end
              default: begin
                if (key < root_value) begin
                  hi    <= index[CNT_W-1:0];
                  state <= ST_PROBE;
                end else if (key > root_value) begin
                  lo    <= index[CNT_W-1:0] + 1'b1;
                  state <= ST_PROBE;
                end else begin
                  res_value <= root_value;
                  res_fpos  <= index[CNT_W-1:0];
                  state     <= ST_RESP;
                end
              end
            endcase
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end

        ST_RESP: begin
          if (resp_load) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a response until it is taken, while the
  // sequencer already works on the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_fpos   <= res_fpos;
      out_count  <= count;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_value     = ITEM_W'(out_value);
  assign rsp.found_position = POS_W'(out_fpos);
  assign rsp.entry_count    = COUNT_W'(out_count);

  // The count never passes the table size.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An insert update adds exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) && (op == CELL_INSERT) |=>
      count == $past(count) + 1'b1)
    else $error("insert did not add one entry");

  // A delete update removes exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) && (op == CELL_DELETE) |=>
      count == $past(count) - 1'b1)
    else $error("delete did not remove one entry");

  // The binary search range never inverts.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (lo <= hi) && (hi <= count))
    else $error("search range inverted");

  // A new response only appears after the sequencer reached its response state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("response raised outside the response state");

endmodule

// ===== dv/oltbl_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list table scoreboard
// Shadow copy of the table that predicts every response and checks the
// responses of the engine in order.
// ----------------------------------------------------------------------------
package oltbl_tb_pkg;
  import oltbl_pkg::*;

  // Command codes that the engine does not define; it must reject them.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [ITEM_W-1:0] VALUE_MASK =
    {ITEM_W{1'b1}} >> (ITEM_W - VALUE_WIDTH_DEF);

  typedef struct packed {
    status_t            status;
    logic [ITEM_W-1:0]  read_value;
    logic [POS_W-1:0]   found_position;
    logic [COUNT_W-1:0] entry_count;
  } table_result_t;

  class table_tracker;
    logic [ITEM_W-1:0] cells [CAPACITY_DEF];
    int unsigned       held;
    int unsigned       peak_held;
    int unsigned       responses_checked;
    int unsigned       error_count;
    int unsigned       code_seen [8];
    int unsigned       outcome_seen [4];
    table_result_t     awaited_results [$];

    function new();
      held = 0;
      peak_held = 0;
      responses_checked = 0;
      error_count = 0;
    endfunction

    // Applies one accepted request to the shadow table and queues the
    // response that the engine owes for it.
    function void note_request(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                               logic [ITEM_W-1:0] value);
      table_result_t     want;
      logic [ITEM_W-1:0] key;
      int unsigned       lo, hi, mid, i;
      bit                hit;
      key = value & VALUE_MASK;
      want = '0;
      want.status = STAT_OK;
      case (code)
        CMD_INSERT: begin
          if (held >= CAPACITY_DEF) begin
            want.status = STAT_FULL;
          end else if (pos > held) begin
            want.status = STAT_RANGE;
          end else begin
            for (i = held; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = key;
            held++;
          end
        end
        CMD_DELETE: begin
          if (pos >= held) begin
            want.status = STAT_RANGE;
          end else begin
            for (i = pos + 1; i < held; i++) cells[i-1] = cells[i];
            held--;
          end
        end
        CMD_GET: begin
          if (pos >= held) want.status = STAT_RANGE;
          else want.read_value = cells[pos];
        end
        CMD_FIND: begin
          want.status = STAT_MISS;
          for (i = 0; i < held; i++) begin
            if (cells[i] == key) begin
              want.status = STAT_OK;
              want.read_value = cells[i];
              want.found_position = POS_W'(i);
              break;
            end
          end
        end
        CMD_SORTED: begin
          lo = 0;
          hi = held;
          hit = 1'b0;
          while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            if (key < cells[mid]) begin
              hi = mid;
            end else if (key > cells[mid]) begin
              lo = mid + 1;
            end else begin
              hit = 1'b1;
              want.read_value = cells[mid];
              want.found_position = POS_W'(mid);
            end
          end
          if (!hit) begin
            want.status = STAT_MISS;
            want.found_position = POS_W'(lo);
          end
        end
        default: want.status = STAT_RANGE;
      endcase
      want.entry_count = COUNT_W'(held);
      if (held > peak_held) peak_held = held;
      code_seen[code]++;
      outcome_seen[want.status]++;
      awaited_results.push_back(want);
    endfunction

    task report_mismatch(string what, logic [ITEM_W-1:0] got,
                         logic [ITEM_W-1:0] want);
      $display("ERROR response %0d: %s is %0h, expected %0h",
               responses_checked, what, got, want);
      error_count++;
    endtask

    task check_response(logic [STATUS_W-1:0] status, logic [ITEM_W-1:0] rd,
                        logic [POS_W-1:0] fpos, logic [COUNT_W-1:0] cnt);
      table_result_t want;
      responses_checked++;
      if (awaited_results.size() == 0) begin
        report_mismatch("response with no request outstanding, status", status, 0);
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (rd !== want.read_value) report_mismatch("read_value", rd, want.read_value);
        if (fpos !== want.found_position)
          report_mismatch("found_position", fpos, want.found_position);
        if (cnt !== want.entry_count)
          report_mismatch("entry_count", cnt, want.entry_count);
      end
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list table engine testbench
// Drives insert, delete, get, find and sorted find requests into the engine,
// predicts every response with a shadow table and checks them in order,
// under random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import oltbl_pkg::*;
  import oltbl_tb_pkg::*;

  // Request mixes of the random part.
  //   MIX_FILL_SORTED: mostly inserts at their sorted place, so the table
  //                    stays ordered, sorted find hits and misses are both
  //                    meaningful, and the table grows until it is full.
  //   MIX_DRAIN:       mostly deletes, plus inserts at arbitrary places, so
  //                    sorted find also runs on an unordered table.
  //   MIX_CHURN:       balanced traffic on a small table with many repeated
  //                    values, crossing the empty table again and again.
  typedef enum {MIX_FILL_SORTED, MIX_DRAIN, MIX_CHURN} traffic_mix_e;

  localparam int unsigned POS_LIMIT       = (1 << POS_W) - 1;
  localparam int          HOLD_OFF_CYCLES = 300;
  // A sorted find on a full table makes up to ten probes through the tree.
  localparam int          SETTLE_CYCLES   = 80;
  // Far beyond the slowest legal run of roughly two thousand requests.
  localparam int          RUN_LIMIT_NS    = 8_000_000;

  logic         clk;
  logic         rst;
  int           sender_idle_pct;
  int           receiver_idle_pct;
  bit           hold_off_requested;
  bit           hold_ready_low;
  table_tracker tracker;

  oltbl_req_if req_ch ();
  oltbl_rsp_if rsp_ch ();

  ordered_list_table_engine u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // Response side. Ready changes on the falling edge only; while the long
  // hold-off runs it stays low no matter what the idle setting says.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= !hold_ready_low && ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // The long hold-off counts its own cycles so that the request side can go
  // on offering requests; the engine fills its response register and then
  // has to stall the request channel. The flag moves on the rising edge so
  // that the falling-edge process above never races with it.
  initial begin
    hold_ready_low = 1'b0;
    wait (hold_off_requested);
    @(posedge clk);
    hold_ready_low = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_ready_low = 1'b0;
  end

  // Every response taken by the receiver is checked against the oldest
  // outstanding prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_response(rsp_ch.status, rsp_ch.read_value,
                             rsp_ch.found_position, rsp_ch.entry_count);
    end
  end

  // Offers one request, with random idle cycles in front of it, and holds it
  // until the engine takes it. The payload and valid change on the falling
  // edge; acceptance is judged at the rising edge.
  task automatic send_request(input logic [CMD_W-1:0] code,
                              input logic [POS_W-1:0] pos,
                              input logic [ITEM_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= code;
    req_ch.position   <= pos;
    req_ch.item_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    tracker.note_request(code, pos, value);
  endtask

  // Values lean toward a handful of small numbers when repeats are wanted,
  // and now and then hit the extremes of the value range.
  function automatic logic [ITEM_W-1:0] pick_value(int unsigned small_pct);
    int unsigned       roll;
    logic [ITEM_W-1:0] v;
    roll = $urandom_range(99);
    if (roll < small_pct) begin
      v = ITEM_W'($urandom_range(0, 31));
    end else if (roll < small_pct + 8) begin
      case ($urandom_range(2))
        0:       v = '0;
        1:       v = '1;
        default: v = {1'b1, {(ITEM_W-1){1'b0}}};
      endcase
    end else begin
      v = {$urandom, $urandom};
    end
    return v & VALUE_MASK;
  endfunction

  // Half of the search keys are taken from the table so that finds hit.
  function automatic logic [ITEM_W-1:0] pick_key(int unsigned held);
    if (held > 0 && $urandom_range(1) == 0) return tracker.cells[$urandom_range(0, held-1)];
    return pick_value(30);
  endfunction

  // Mostly a live index; the rest spans the whole position field.
  function automatic logic [POS_W-1:0] pick_index(int unsigned held);
    if (held > 0 && $urandom_range(99) < 85) return POS_W'($urandom_range(0, held-1));
    return POS_W'($urandom_range(0, POS_LIMIT));
  endfunction

  task automatic run_random(input traffic_mix_e mix);
    int unsigned       roll, held, slot;
    int unsigned       w_ins, w_del, w_get, w_find, w_sorted;
    logic [CMD_W-1:0]  code;
    logic [POS_W-1:0]  pos;
    logic [ITEM_W-1:0] value;
    held  = tracker.held;
    roll  = $urandom_range(99);
    pos   = POS_W'($urandom_range(0, POS_LIMIT));
    value = {$urandom, $urandom};
    // Cumulative weights out of a hundred.
    case (mix)
      MIX_FILL_SORTED: begin
        w_ins = 85; w_del = 88; w_get = 92; w_find = 95; w_sorted = 99;
      end
      MIX_DRAIN: begin
        w_ins = 6; w_del = 81; w_get = 86; w_find = 91; w_sorted = 97;
      end
      default: begin
        w_ins = 32; w_del = 60; w_get = 70; w_find = 80; w_sorted = 95;
      end
    endcase
    if (roll < w_ins) begin
      code  = CMD_INSERT;
      value = pick_value(mix == MIX_CHURN ? 60 : 20);
      if (mix == MIX_FILL_SORTED) begin
        // A few inserts past the end are rejected; all others go in front of
        // the first entry that is not smaller, which keeps the order.
        if ($urandom_range(19) == 0) begin
          pos = POS_W'($urandom_range(held + 1, POS_LIMIT));
        end else begin
          slot = 0;
          while (slot < held && tracker.cells[slot] < value) slot++;
          pos = POS_W'(slot);
        end
      end else if ($urandom_range(3) != 0) begin
        pos = POS_W'($urandom_range(0, held));
      end
    end else if (roll < w_del) begin
      code = CMD_DELETE;
      pos  = pick_index(held);
    end else if (roll < w_get) begin
      code = CMD_GET;
      pos  = pick_index(held);
    end else if (roll < w_find) begin
      code  = CMD_FIND;
      value = pick_key(held);
    end else if (roll < w_sorted) begin
      code  = CMD_SORTED;
      value = pick_key(held);
    end else begin
      code = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end
    send_request(code, pos, value);
  endtask

  initial begin
    int unsigned issued;
    int unsigned full_tries;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.command      = '0;
    req_ch.position     = '0;
    req_ch.item_value   = '0;
    sender_idle_pct     = 0;
    receiver_idle_pct   = 0;
    hold_off_requested  = 1'b0;
    tracker             = new();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. On the empty table every read and delete is out of
    // range, a find misses and a sorted find points at the front.
    send_request(CMD_GET, '0, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_FIND, '0, '0);
    send_request(CMD_SORTED, '0, ITEM_W'(5));
    // The unused codes, with every other field at its top.
    for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++) begin
      send_request(CMD_W'(k), POS_W'(POS_LIMIT), '1);
    end
    // An insert past the end is rejected; then build the table
    // zero, top bit only, all ones, which is in ascending order.
    send_request(CMD_INSERT, POS_W'(1), ITEM_W'(5));
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, POS_W'(1), '1);
    send_request(CMD_INSERT, POS_W'(1), {1'b1, {(ITEM_W-1){1'b0}}});
    send_request(CMD_INSERT, POS_W'(POS_LIMIT), ITEM_W'(7));
    // Reads of the middle entry, the last entry and one past it, then a find of all ones.
    send_request(CMD_GET, POS_W'(1), '0);
    send_request(CMD_GET, POS_W'(2), '0);
    send_request(CMD_GET, POS_W'(3), '0);
    send_request(CMD_FIND, '0, '1);
    // Sorted find: hits in the middle, at both ends, and a miss between.
    send_request(CMD_SORTED, '0, {1'b1, {(ITEM_W-1){1'b0}}});
    send_request(CMD_SORTED, '0, ITEM_W'(7));
    send_request(CMD_SORTED, '0, '1);
    send_request(CMD_SORTED, '0, '0);
    // Delete past the end, then the last, then the first twice, which
    // leaves the table empty again.
    send_request(CMD_DELETE, POS_W'(3), '0);
    send_request(CMD_DELETE, POS_W'(2), '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_DELETE, '0, '0);

    // Fill the table in sorted order until inserts have met a full table a
    // number of times. The sender rarely pauses, the receiver often does.
    sender_idle_pct   = 15;
    receiver_idle_pct = 75;
    issued     = 0;
    full_tries = 0;
    while (full_tries < 20 && issued < 900) begin
      if (tracker.held == CAPACITY_DEF) full_tries++;
      run_random(MIX_FILL_SORTED);
      issued++;
    end

    // Drain it nearly empty with the roles of the two sides swapped.
    sender_idle_pct   = 75;
    receiver_idle_pct = 15;
    issued = 0;
    while (tracker.held > 2 && issued < 1100) begin
      run_random(MIX_DRAIN);
      issued++;
    end

    // Full speed on a small table, starting under the long hold-off.
    sender_idle_pct    = 0;
    receiver_idle_pct  = 0;
    hold_off_requested = 1'b1;
    repeat (250) run_random(MIX_CHURN);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d inserts, %0d deletes, %0d gets, %0d finds, %0d sorted finds",
             tracker.code_seen[CMD_INSERT], tracker.code_seen[CMD_DELETE],
             tracker.code_seen[CMD_GET], tracker.code_seen[CMD_FIND],
             tracker.code_seen[CMD_SORTED]);
    $display("Outcomes: %0d ok, %0d full, %0d out of range, %0d not found; peak %0d entries",
             tracker.outcome_seen[STAT_OK], tracker.outcome_seen[STAT_FULL],
             tracker.outcome_seen[STAT_RANGE], tracker.outcome_seen[STAT_MISS],
             tracker.peak_held);
    if (tracker.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
